// File: rtl/dstq_pkg.sv
// ----------------------------------------------------------------------------
// dstq_pkg
// Shared types and codes for the deadline-sorted task queue.
// ----------------------------------------------------------------------------
package dstq_pkg;

  localparam int unsigned WORD_W = 32;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_POP    = 2'd2,
    KIND_EXPIRE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    STAT_INSERTED     = 3'd0,
    STAT_REMOVED      = 3'd1,
    STAT_POPPED       = 3'd2,
    STAT_EXPIRED      = 3'd3,
    STAT_FULL         = 3'd4,
    STAT_EMPTY        = 3'd5,
    STAT_NOT_FOUND    = 3'd6,
    STAT_NONE_OVERDUE = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_EXEC   = 2'd1,
    S_REPORT = 2'd2
  } state_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_SHIFT  = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic [WORD_W-1:0] ident;
    logic [WORD_W-1:0] due;
    logic              periodic;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    cell_op_e op;
    entry_t   ent;
  } cell_cmd_t;

endpackage

// File: rtl/dstq_cell.sv
// ----------------------------------------------------------------------------
// dstq_cell
// One slot of the sorted queue: holds an entry, takes the new entry or a
// neighbor's entry on insert, and the right neighbor's entry on removal.
// ----------------------------------------------------------------------------
module dstq_cell import dstq_pkg::*; (
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      occupied,
  input  logic      left_le,
  input  entry_t    left_entry,
  input  entry_t    right_entry,
  input  logic      seen_in,
  output entry_t    entry,
  output logic      le,
  output logic      seen_out,
  output logic      hit
);

  logic   match;
  entry_t entry_next;

  // equal deadlines stay ahead of the new entry
  assign le       = occupied && (entry.due <= cmd.ent.due);
  assign match    = occupied && (entry.ident == cmd.ent.ident);
  assign seen_out = seen_in | match;
  assign hit      = match & ~seen_in;

  always_comb begin
    entry_next = entry;
    case (cmd.op)
      CELL_INSERT: begin
        if (!le) begin
          entry_next = left_le ? cmd.ent : left_entry;
        end
      end
      CELL_SHIFT: begin
        // at and after the removed slot, close the gap
        if (seen_out) begin
          entry_next = right_entry;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// File: rtl/deadline_sorted_task_queue_core.sv
// ----------------------------------------------------------------------------
// deadline_sorted_task_queue_core
// Earliest-deadline-first task queue built as a row of shifting cells.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Insert, remove,
// pop and an expire that finds nothing overdue each pass an exec state,
// where the row of cells compares and shifts in parallel, then a report
// state, where the single result beat is shown with valid high. In the
// report state busy is already low, so a new command can be taken there.
// An expire run gives one beat per expelled entry, each with its own exec
// and report state, since the head cell shifts out one entry per pass;
// busy stays high until the beat with last set. Results cannot be held
// off: each is on the ports for exactly the one cycle in which valid is high.
module deadline_sorted_task_queue_core import dstq_pkg::*; #(
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        kind,
  input  logic [WORD_W-1:0] task_ident,
  input  logic [WORD_W-1:0] due_tick,
  input  logic              is_periodic,
  input  logic [WORD_W-1:0] now_tick,
  output logic              valid,
  output logic [2:0]        status,
  output logic [WORD_W-1:0] entry_ident,
  output logic [WORD_W-1:0] entry_due,
  output logic              entry_periodic,
  output logic [WORD_W-1:0] head_ident,
  output logic [CNT_W-1:0]  occupancy,
  output logic              last
);

  state_e             state, state_next;
  logic [CNT_W-1:0]   held_count, held_count_next;

  kind_e              cmd_kind;
  logic [WORD_W-1:0]  cmd_ident;
  logic [WORD_W-1:0]  cmd_due;
  logic               cmd_periodic;
  logic [WORD_W-1:0]  cmd_now;

  status_e            res_status, res_status_next;
  entry_t             res_entry, res_entry_next;
  logic               res_last, res_last_next;

  cell_cmd_t          cell_cmd;
  entry_t             cell_entry [DEPTH];
  entry_t             left_ent   [DEPTH];
  entry_t             right_ent  [DEPTH];
  logic [DEPTH-1:0]   le;
  logic [DEPTH-1:0]   left_le;
  logic [DEPTH-1:0]   hit;
  logic [DEPTH-1:0]   occupied;
  logic [DEPTH:0]     seen;
  entry_t             hit_entry;
  logic               accept;
  logic               full;
  logic               found;
  logic               overdue_head;
  logic               overdue_next;

  assign accept = start && !busy;

  // row of cells
  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      assign occupied[i] = CNT_W'(i) < held_count;
      if (i == 0) begin : g_left_end
        assign left_le[i]  = 1'b1;
        assign left_ent[i] = '0;
      end else begin : g_left
        assign left_le[i]  = le[i-1];
        assign left_ent[i] = cell_entry[i-1];
      end
      if (i == DEPTH - 1) begin : g_right_end
        assign right_ent[i] = '0;
      end else begin : g_right
        assign right_ent[i] = cell_entry[i+1];
      end
      dstq_cell u_cell (
        .clk         (clk),
        .cmd         (cell_cmd),
        .occupied    (occupied[i]),
        .left_le     (left_le[i]),
        .left_entry  (left_ent[i]),
        .right_entry (right_ent[i]),
        .seen_in     (seen[i]),
        .entry       (cell_entry[i]),
        .le          (le[i]),
        .seen_out    (seen[i+1]),
        .hit         (hit[i])
      );
    end
  endgenerate

  // pop and expire shift the whole row from the head
  assign seen[0] = (cmd_kind != KIND_REMOVE);
  assign found   = |hit;

  always_comb begin
    hit_entry = '0;
    for (int k = 0; k < DEPTH; k++) begin
      hit_entry = hit_entry | (cell_entry[k] & {ENTRY_W{hit[k]}});
    end
  end

  assign full         = (held_count == CNT_W'(DEPTH));
  assign overdue_head = cell_entry[0].due < cmd_now;
  assign overdue_next = cell_entry[1].due < cmd_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_count <= '0;
    end else begin
      state      <= state_next;
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_kind     <= kind_e'(kind);
      cmd_ident    <= task_ident;
      cmd_due      <= due_tick;
      cmd_periodic <= is_periodic;
      cmd_now      <= now_tick;
    end
    if (state == S_EXEC) begin
      res_status <= res_status_next;
      res_entry  <= res_entry_next;
      res_last   <= res_last_next;
    end
  end

  always_comb begin
    state_next      = state;
    held_count_next = held_count;
    res_status_next = STAT_EMPTY;
    res_entry_next  = '0;
    res_last_next   = 1'b1;
    cell_cmd.op     = CELL_HOLD;
    cell_cmd.ent    = '{ident: cmd_ident, due: cmd_due, periodic: cmd_periodic};
    busy            = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        busy       = 1'b1;
        state_next = S_REPORT;
        if (cmd_kind == KIND_INSERT) begin
          if (full) begin
            res_status_next = STAT_FULL;
          end else begin
            cell_cmd.op     = CELL_INSERT;
            held_count_next = held_count + CNT_W'(1);
            res_status_next = STAT_INSERTED;
          end
        end else if (held_count == '0) begin
          res_status_next = STAT_EMPTY;
        end else begin
          case (cmd_kind)
            KIND_REMOVE: begin
              if (found) begin
                cell_cmd.op     = CELL_SHIFT;
                held_count_next = held_count - CNT_W'(1);
                res_status_next = STAT_REMOVED;
                res_entry_next  = hit_entry;
              end else begin
                res_status_next = STAT_NOT_FOUND;
              end
            end
            KIND_POP: begin
              cell_cmd.op     = CELL_SHIFT;
              held_count_next = held_count - CNT_W'(1);
              res_status_next = STAT_POPPED;
              res_entry_next  = cell_entry[0];
            end
            KIND_EXPIRE: begin
              if (overdue_head) begin
                cell_cmd.op     = CELL_SHIFT;
                held_count_next = held_count - CNT_W'(1);
                res_status_next = STAT_EXPIRED;
                res_entry_next  = cell_entry[0];
                res_last_next   = (held_count == CNT_W'(1)) || !overdue_next;
              end else begin
                res_status_next = STAT_NONE_OVERDUE;
              end
            end
            default: begin
              res_status_next = STAT_EMPTY;
            end
          endcase
        end
      end
      S_REPORT: begin
        busy = !res_last;
        if (!res_last) begin
          state_next = S_EXEC;
        end else if (start) begin
          state_next = S_EXEC;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign valid          = (state == S_REPORT);
  assign status         = res_status;
  assign entry_ident    = res_entry.ident;
  assign entry_due      = res_entry.due;
  assign entry_periodic = res_entry.periodic;
  assign last           = res_last;
  assign occupancy      = held_count;
  assign head_ident     = (held_count != '0) ? cell_entry[0].ident : '0;

`ifndef ASSERT_OFF
  // never more entries than cells
  assert property (@(posedge clk) disable iff (rst)
    occupancy <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  // a full report only comes from a full queue
  assert property (@(posedge clk) disable iff (rst)
    valid && (status == STAT_FULL) |-> occupancy == CNT_W'(DEPTH))
    else $error("full reported on a queue with room");

  // each result beat lasts one cycle
  assert property (@(posedge clk) disable iff (rst)
    valid |=> !valid)
    else $error("result beat longer than one cycle");

  // an accepted command gives no beat in the following cycle
  assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !valid && busy)
    else $error("command did not enter the compare cycle");
`endif

endmodule
